@@ hw/rtl/cbm_pkg.sv @@
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and codes for the cartridge bank mapper with scanline IRQ.
// ----------------------------------------------------------------------------
package cbm_pkg;

	localparam logic [1:0] OP_CPU_WRITE    = 2'd0;
	localparam logic [1:0] OP_CPU_READ     = 2'd1;
	localparam logic [1:0] OP_SCANLINE_END = 2'd2;
	localparam logic [1:0] OP_PATTERN_READ = 2'd3;

	// CPU write pages, address bits 15..12
	localparam logic [3:0] PAGE_PRG_WIDE   = 4'h8;
	localparam logic [3:0] PAGE_MIRROR     = 4'hB;
	localparam logic [3:0] PAGE_PRG_NARROW = 4'hC;
	localparam logic [3:0] PAGE_PAT_LOW    = 4'hD;
	localparam logic [3:0] PAGE_PAT_HIGH   = 4'hE;
	localparam logic [3:0] PAGE_IRQ        = 4'hF;

	// IRQ page registers, address bits 1..0
	localparam logic [1:0] IRQ_RELOAD  = 2'd0;
	localparam logic [1:0] IRQ_CONTROL = 2'd1;
	localparam logic [1:0] IRQ_ACK     = 2'd2;
	localparam logic [1:0] IRQ_NONE    = 2'd3;

	// CPU read windows, address bits 15..13
	localparam logic [2:0] WIN_8000 = 3'd4;
	localparam logic [2:0] WIN_A000 = 3'd5;
	localparam logic [2:0] WIN_C000 = 3'd6;
	localparam logic [2:0] WIN_E000 = 3'd7;

	localparam int unsigned ROM_AW = 22;
	localparam int unsigned PAT_AW = 18;

	localparam logic [0:0] CFG_PRG_BANKS = 1'b0;
	localparam logic [0:0] CFG_CHR_BANKS = 1'b1;

	typedef struct packed {
		logic [8:0]      prg_banks;
		logic [7:0]      prg_wide;
		logic [7:0]      prg_narrow;
		logic [7:0][7:0] pattern_bank;
	} bank_state_t;

	typedef struct packed {
		logic [ROM_AW-1:0] rom_address;
		logic              rom_hit;
		logic [PAT_AW-1:0] pattern_address;
		logic              irq_pulse;
		logic [1:0]        mirroring;
	} result_t;

endpackage

@@ hw/rtl/cbm_regs.sv @@
// ----------------------------------------------------------------------------
// cbm_regs
// Bank, mirroring and IRQ registers; CPU write decode and scanline counter.
// ----------------------------------------------------------------------------
module cbm_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_index,
	input  logic [8:0]           cfg_data,
	input  logic                 fire,
	input  logic [1:0]           operation,
	input  logic [15:0]          address,
	input  logic [7:0]           write_data,
	output cbm_pkg::bank_state_t st,
	output logic [1:0]           mirror_next,
	output logic                 irq
);

	logic [8:0]      prg_banks_q;
	logic [8:0]      chr_banks_q;
	logic [7:0]      prg_wide_q;
	logic [7:0]      prg_narrow_q;
	logic [7:0][7:0] pattern_bank_q;
	logic [7:0]      irq_reload_q;
	logic [7:0]      irq_counter_q;
	logic [1:0]      irq_control_q;
	logic [1:0]      mirror_q;

	logic [7:0]      prg_wide_d;
	logic [7:0]      prg_narrow_d;
	logic [7:0][7:0] pattern_bank_d;
	logic [7:0]      irq_reload_d;
	logic [7:0]      irq_counter_d;
	logic [1:0]      irq_control_d;
	logic [1:0]      mirror_d;
	logic            irq_d;

	logic [8:0] wide_m9;
	logic [7:0] narrow_mask;
	logic [8:0] chr_m9;
	logic [7:0] counter_dec;

	assign wide_m9     = prg_banks_q - 9'd1;
	assign narrow_mask = {prg_banks_q[6:0], 1'b0} - 8'd1;
	assign chr_m9      = chr_banks_q - 9'd1;
	assign counter_dec = irq_counter_q - 8'd1;

	always_comb begin
		prg_wide_d     = prg_wide_q;
		prg_narrow_d   = prg_narrow_q;
		pattern_bank_d = pattern_bank_q;
		irq_reload_d   = irq_reload_q;
		irq_counter_d  = irq_counter_q;
		irq_control_d  = irq_control_q;
		mirror_d       = mirror_q;
		irq_d          = 1'b0;
		if (fire) begin
			unique case (operation)
				cbm_pkg::OP_CPU_WRITE: begin
					unique case (address[15:12])
						cbm_pkg::PAGE_PRG_WIDE:   prg_wide_d = write_data & wide_m9[7:0];
						cbm_pkg::PAGE_MIRROR:     mirror_d = write_data[3:2];
						cbm_pkg::PAGE_PRG_NARROW: prg_narrow_d = write_data & narrow_mask;
						cbm_pkg::PAGE_PAT_LOW:
							pattern_bank_d[{1'b0, address[1:0]}] = write_data & chr_m9[7:0];
						cbm_pkg::PAGE_PAT_HIGH:
							pattern_bank_d[{1'b1, address[1:0]}] = write_data & chr_m9[7:0];
						cbm_pkg::PAGE_IRQ: begin
							unique case (address[1:0])
								cbm_pkg::IRQ_RELOAD: irq_reload_d = write_data;
								cbm_pkg::IRQ_CONTROL: begin
									irq_control_d = write_data[1:0];
									if (write_data[1]) begin
										irq_counter_d = irq_reload_q;
									end
								end
								cbm_pkg::IRQ_ACK:
									irq_control_d = {irq_control_q[0], irq_control_q[0]};
								cbm_pkg::IRQ_NONE: ;
							endcase
						end
						default: ;
					endcase
				end
				cbm_pkg::OP_CPU_READ: ;
				cbm_pkg::OP_SCANLINE_END: begin
					if (irq_control_q[1]) begin
						irq_counter_d = counter_dec;
						irq_d         = (counter_dec == 8'd0);
					end
				end
				cbm_pkg::OP_PATTERN_READ: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_banks_q    <= 9'd1;
			chr_banks_q    <= 9'd8;
			prg_wide_q     <= '0;
			prg_narrow_q   <= '0;
			pattern_bank_q <= '0;
			irq_reload_q   <= '0;
			irq_counter_q  <= '0;
			irq_control_q  <= '0;
			mirror_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					cbm_pkg::CFG_PRG_BANKS: prg_banks_q <= cfg_data;
					cbm_pkg::CFG_CHR_BANKS: chr_banks_q <= cfg_data;
				endcase
			end
			prg_wide_q     <= prg_wide_d;
			prg_narrow_q   <= prg_narrow_d;
			pattern_bank_q <= pattern_bank_d;
			irq_reload_q   <= irq_reload_d;
			irq_counter_q  <= irq_counter_d;
			irq_control_q  <= irq_control_d;
			mirror_q       <= mirror_d;
		end
	end

	assign st.prg_banks    = prg_banks_q;
	assign st.prg_wide     = prg_wide_q;
	assign st.prg_narrow   = prg_narrow_q;
	assign st.pattern_bank = pattern_bank_q;
	assign mirror_next     = mirror_d;
	assign irq             = irq_d;

endmodule

@@ hw/rtl/cbm_xlate.sv @@
// ----------------------------------------------------------------------------
// cbm_xlate
// Program and pattern ROM address translation from the current bank state.
// ----------------------------------------------------------------------------
module cbm_xlate (
	input  cbm_pkg::bank_state_t          st,
	input  logic [1:0]                    operation,
	input  logic [15:0]                   address,
	output logic [cbm_pkg::ROM_AW-1:0]    rom_address,
	output logic                          rom_hit,
	output logic [cbm_pkg::PAT_AW-1:0]    pattern_address
);

	logic [8:0] last_page;

	// last 8 KB page: banks * 2 - 1, wrapped to the ROM address width
	assign last_page = {st.prg_banks[7:0], 1'b0} - 9'd1;

	always_comb begin
		rom_address     = '0;
		rom_hit         = 1'b0;
		pattern_address = '0;
		unique case (operation)
			cbm_pkg::OP_CPU_READ: begin
				unique case (address[15:13])
					cbm_pkg::WIN_8000, cbm_pkg::WIN_A000: begin
						rom_address = {st.prg_wide, address[13:0]};
						rom_hit     = 1'b1;
					end
					cbm_pkg::WIN_C000: begin
						rom_address = {1'b0, st.prg_narrow, address[12:0]};
						rom_hit     = 1'b1;
					end
					cbm_pkg::WIN_E000: begin
						rom_address = {last_page, address[12:0]};
						rom_hit     = 1'b1;
					end
					default: ;
				endcase
			end
			cbm_pkg::OP_PATTERN_READ:
				pattern_address = {st.pattern_bank[address[12:10]], address[9:0]};
			cbm_pkg::OP_CPU_WRITE, cbm_pkg::OP_SCANLINE_END: ;
		endcase
	end

endmodule

@@ hw/rtl/cbm_skid.sv @@
// ----------------------------------------------------------------------------
// cbm_skid
// Result register with a skid stage so that a transfer in is taken while a
// result waits at the output.
// ----------------------------------------------------------------------------
module cbm_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  cbm_pkg::result_t  res,
	output logic              full,
	output logic              out_valid,
	input  logic              out_stall,
	output cbm_pkg::result_t  out_res
);

	logic             out_valid_q;
	cbm_pkg::result_t out_q;
	logic             skid_valid_q;
	cbm_pkg::result_t skid_q;
	logic             hold;

	assign hold = out_valid_q & out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (hold) begin
			if (load) begin
				skid_valid_q <= 1'b1;
			end
		end else if (skid_valid_q) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (hold) begin
			if (load) begin
				skid_q <= res;
			end
		end else if (skid_valid_q) begin
			out_q <= skid_q;
		end else if (load) begin
			out_q <= res;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

@@ hw/rtl/cartridge_bank_mapper_irq.sv @@
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_irq
// A result is registered at the output, or in the skid entry while stalled.
// Throughput: one item per cycle when not stalled; state updates on transfer.
// A two-entry result buffer keeps the input open for one more item while the
// output is stalled. arst_n clears all bank and IRQ state, sets 1 program and
// 8 pattern banks, and empties the result buffer.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_irq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_index,
	input  logic [8:0]                    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    operation,
	input  logic [15:0]                   address,
	input  logic [7:0]                    write_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [cbm_pkg::ROM_AW-1:0]    rom_address,
	output logic                          rom_hit,
	output logic [cbm_pkg::PAT_AW-1:0]    pattern_address,
	output logic                          irq_pulse,
	output logic [1:0]                    mirroring
);

	logic                       fire;
	logic                       full;
	cbm_pkg::bank_state_t       st;
	logic [1:0]                 mirror_next;
	logic                       irq;
	logic [cbm_pkg::ROM_AW-1:0] xl_rom_address;
	logic                       xl_rom_hit;
	logic [cbm_pkg::PAT_AW-1:0] xl_pattern_address;
	cbm_pkg::result_t           res;
	cbm_pkg::result_t           out_res;

	assign in_stall = full;
	assign fire     = in_valid & ~full;

	cbm_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fire        (fire),
		.operation   (operation),
		.address     (address),
		.write_data  (write_data),
		.st          (st),
		.mirror_next (mirror_next),
		.irq         (irq)
	);

	cbm_xlate u_xlate (
		.st              (st),
		.operation       (operation),
		.address         (address),
		.rom_address     (xl_rom_address),
		.rom_hit         (xl_rom_hit),
		.pattern_address (xl_pattern_address)
	);

	assign res = {xl_rom_address, xl_rom_hit, xl_pattern_address, irq, mirror_next};

	cbm_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.res       (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign rom_address     = out_res.rom_address;
	assign rom_hit         = out_res.rom_hit;
	assign pattern_address = out_res.pattern_address;
	assign irq_pulse       = out_res.irq_pulse;
	assign mirroring       = out_res.mirroring;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("skid entry held with no result at the output");

	a_transfer_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (!out_valid || !out_stall)) |=> out_valid)
		else $error("accepted transfer produced no result");

	a_result_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rom_hit) |-> (pattern_address == '0 && !irq_pulse))
		else $error("cpu read result carries pattern or irq data");

	a_irq_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && irq_pulse) |-> (rom_address == '0 && pattern_address == '0))
		else $error("irq result carries an address");

endmodule
